[rtl/mie_pkg.sv]
// Shared types, codes and helper functions for the MIPS32 integer execute block.
// Depends on nothing; used by every other file of the block but mie_if.
package mie_pkg;

	localparam int unsigned XlenC = 32;
	localparam int unsigned QueueDepthC = 2;

	typedef enum logic [2:0] {
		ST_OK   = 3'd0,
		ST_OV   = 3'd1,
		ST_TRAP = 3'd2,
		ST_SYS  = 3'd3,
		ST_EXT  = 3'd4,
		ST_INV  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_MULT  = 3'd1,
		OP_MULTU = 3'd2,
		OP_DIV   = 3'd3,
		OP_DIVU  = 3'd4,
		OP_MFHI  = 3'd5,
		OP_MFLO  = 3'd6,
		OP_MTHI  = 3'd7
	} hl_op_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] val;
		logic [4:0]  dst;
		logic        wr;
		logic [31:0] npc;
		status_t     st;
		hl_op_t      hl;
		logic        mtlo;
	} work_t;

	function automatic logic lt_signed(input logic [31:0] x, input logic [31:0] y);
		return $signed(x) < $signed(y);
	endfunction

	function automatic logic [31:0] clz32(input logic [31:0] x);
		logic [5:0] n;
		n = 6'd32;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) n = 6'(31 - i);
		end
		return {26'd0, n};
	endfunction

endpackage

[rtl/mie_if.sv]
// Valid/ready channel interface carrying one payload per beat.
// Payload type is a parameter; no package dependency.
interface mie_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/mie_front.sv]
// Front end: decodes one instruction and computes everything except HI/LO work.
// Depends on mie_pkg.
module mie_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [31:0]      instruction,
	input  logic [31:0]      pc,
	input  logic [31:0]      rs_value,
	input  logic [31:0]      rt_value,
	output logic             q_valid,
	input  logic             q_ready,
	output mie_pkg::work_t   q_data
);

	logic [5:0] op, fn;
	logic [4:0] rs, rt, rd, sa;
	logic [31:0] a, b, uimm, simm, seq, bt, p8, r, mulp;
	mie_pkg::work_t w;

	assign op = instruction[31:26];
	assign rs = instruction[25:21];
	assign rt = instruction[20:16];
	assign rd = instruction[15:11];
	assign sa = instruction[10:6];
	assign fn = instruction[5:0];
	assign a = rs_value;
	assign b = rt_value;
	assign uimm = {16'd0, instruction[15:0]};
	assign simm = {{16{instruction[15]}}, instruction[15:0]};
	assign seq = pc + 32'd4;
	assign p8 = pc + 32'd8;
	assign bt = seq + {simm[29:0], 2'b00};
	assign mulp = a * b;

	always_comb begin
		w = '0;
		w.a = a;
		w.b = b;
		w.npc = seq;
		w.st = mie_pkg::ST_OK;
		w.hl = mie_pkg::OP_NONE;
		r = '0;
		unique case (op)
			6'd0: begin
				unique case (fn)
					6'd0: if (rs == 5'd0) begin w.wr = 1'b1; w.dst = rd; w.val = b << sa; end
						else w.st = mie_pkg::ST_INV;
					6'd2: if (rs == 5'd0) begin w.wr = 1'b1; w.dst = rd; w.val = b >> sa; end
						else w.st = mie_pkg::ST_INV;
					6'd3: if (rs == 5'd0) begin
							w.wr = 1'b1; w.dst = rd; w.val = $unsigned($signed(b) >>> sa);
						end else w.st = mie_pkg::ST_INV;
					6'd4: if (sa == 5'd0) begin w.wr = 1'b1; w.dst = rd; w.val = b << a[4:0]; end
						else w.st = mie_pkg::ST_INV;
					6'd6: if (sa == 5'd0) begin w.wr = 1'b1; w.dst = rd; w.val = b >> a[4:0]; end
						else w.st = mie_pkg::ST_INV;
					6'd7: if (sa == 5'd0) begin
							w.wr = 1'b1; w.dst = rd; w.val = $unsigned($signed(b) >>> a[4:0]);
						end else w.st = mie_pkg::ST_INV;
					6'd8: if (rt == 5'd0 && rd == 5'd0 && (sa == 5'd0 || sa == 5'd16)) w.npc = a;
						else w.st = mie_pkg::ST_INV;
					6'd9: if (rt == 5'd0 && (sa == 5'd0 || sa == 5'd16)) begin
							w.wr = 1'b1; w.dst = rd; w.val = p8; w.npc = a;
						end else w.st = mie_pkg::ST_INV;
					6'd10: if (sa == 5'd0) begin
							if (b == 32'd0) begin w.wr = 1'b1; w.dst = rd; w.val = a; end
						end else w.st = mie_pkg::ST_INV;
					6'd11: if (sa == 5'd0) begin
							if (b != 32'd0) begin w.wr = 1'b1; w.dst = rd; w.val = a; end
						end else w.st = mie_pkg::ST_INV;
					6'd12: w.st = mie_pkg::ST_SYS;
					6'd15: if (rs != 5'd0 || rt != 5'd0 || rd != 5'd0) w.st = mie_pkg::ST_INV;
					6'd16: if (rs == 5'd0 && rt == 5'd0 && sa == 5'd0) begin
							w.wr = 1'b1; w.dst = rd; w.hl = mie_pkg::OP_MFHI;
						end else w.st = mie_pkg::ST_INV;
					6'd18: if (rs == 5'd0 && rt == 5'd0 && sa == 5'd0) begin
							w.wr = 1'b1; w.dst = rd; w.hl = mie_pkg::OP_MFLO;
						end else w.st = mie_pkg::ST_INV;
					6'd17: if (rt == 5'd0 && rd == 5'd0 && sa == 5'd0) w.hl = mie_pkg::OP_MTHI;
						else w.st = mie_pkg::ST_INV;
					6'd19: if (rt == 5'd0 && rd == 5'd0 && sa == 5'd0) w.mtlo = 1'b1;
						else w.st = mie_pkg::ST_INV;
					6'd24, 6'd25, 6'd26, 6'd27: begin
						if (rd != 5'd0 || sa != 5'd0) w.st = mie_pkg::ST_INV;
						else begin
							priority case (fn)
								6'd24: w.hl = mie_pkg::OP_MULT;
								6'd25: w.hl = mie_pkg::OP_MULTU;
								6'd26: w.hl = mie_pkg::OP_DIV;
								default: w.hl = mie_pkg::OP_DIVU;
							endcase
						end
					end
					6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd42, 6'd43: begin
						if (sa != 5'd0) w.st = mie_pkg::ST_INV;
						else begin
							w.wr = 1'b1;
							w.dst = rd;
							priority case (fn)
								6'd32: begin
									r = a + b; w.val = r;
									if ((a[31] ^ r[31]) & (b[31] ^ r[31])) w.st = mie_pkg::ST_OV;
								end
								6'd33: w.val = a + b;
								6'd34: begin
									r = a - b; w.val = r;
									if ((a[31] ^ b[31]) & (a[31] ^ r[31])) w.st = mie_pkg::ST_OV;
								end
								6'd35: w.val = a - b;
								6'd36: w.val = a & b;
								6'd37: w.val = a | b;
								6'd38: w.val = a ^ b;
								6'd39: w.val = ~(a | b);
								6'd42: w.val = {31'd0, mie_pkg::lt_signed(a, b)};
								default: w.val = {31'd0, a < b};
							endcase
						end
					end
					6'd48: if (!mie_pkg::lt_signed(a, b)) w.st = mie_pkg::ST_TRAP;
					6'd49: if (a >= b) w.st = mie_pkg::ST_TRAP;
					6'd50: if (mie_pkg::lt_signed(a, b)) w.st = mie_pkg::ST_TRAP;
					6'd51: if (a < b) w.st = mie_pkg::ST_TRAP;
					6'd52: if (a == b) w.st = mie_pkg::ST_TRAP;
					6'd54: if (a != b) w.st = mie_pkg::ST_TRAP;
					default: w.st = mie_pkg::ST_INV;
				endcase
			end
			6'd1: begin
				unique case (rt)
					5'd0, 5'd16: begin
						if (a[31] && rt == 5'd16) begin w.wr = 1'b1; w.dst = 5'd31; w.val = p8; end
						w.npc = a[31] ? bt : p8;
					end
					5'd1, 5'd17: begin
						if (!a[31] && rt == 5'd17) begin w.wr = 1'b1; w.dst = 5'd31; w.val = p8; end
						w.npc = !a[31] ? bt : p8;
					end
					5'd8: if (!mie_pkg::lt_signed(a, simm)) w.st = mie_pkg::ST_TRAP;
					5'd9: if (a >= simm) w.st = mie_pkg::ST_TRAP;
					5'd10: if (mie_pkg::lt_signed(a, simm)) w.st = mie_pkg::ST_TRAP;
					5'd11: if (a < simm) w.st = mie_pkg::ST_TRAP;
					5'd12: if (a == simm) w.st = mie_pkg::ST_TRAP;
					5'd14: if (a != simm) w.st = mie_pkg::ST_TRAP;
					default: w.st = mie_pkg::ST_INV;
				endcase
			end
			6'd2, 6'd3: begin
				if (op == 6'd3) begin w.wr = 1'b1; w.dst = 5'd31; w.val = p8; end
				w.npc = {seq[31:28], instruction[25:0], 2'b00};
			end
			6'd4: w.npc = (a == b) ? bt : p8;
			6'd5: w.npc = (a != b) ? bt : p8;
			6'd6: if (rt == 5'd0) w.npc = (a == 32'd0 || a[31]) ? bt : p8;
				else w.st = mie_pkg::ST_INV;
			6'd7: if (rt == 5'd0) w.npc = (a != 32'd0 && !a[31]) ? bt : p8;
				else w.st = mie_pkg::ST_INV;
			6'd8: begin
				r = a + simm; w.wr = 1'b1; w.dst = rt; w.val = r;
				if ((a[31] ^ r[31]) & (simm[31] ^ r[31])) w.st = mie_pkg::ST_OV;
			end
			6'd9: begin w.wr = 1'b1; w.dst = rt; w.val = a + simm; end
			6'd10: begin w.wr = 1'b1; w.dst = rt; w.val = {31'd0, mie_pkg::lt_signed(a, simm)}; end
			6'd11: begin w.wr = 1'b1; w.dst = rt; w.val = {31'd0, a < simm}; end
			6'd12: begin w.wr = 1'b1; w.dst = rt; w.val = a & uimm; end
			6'd13: begin w.wr = 1'b1; w.dst = rt; w.val = a | uimm; end
			6'd14: begin w.wr = 1'b1; w.dst = rt; w.val = a ^ uimm; end
			6'd15: if (rs == 5'd0) begin w.wr = 1'b1; w.dst = rt; w.val = {uimm[15:0], 16'd0}; end
				else w.st = mie_pkg::ST_INV;
			6'd16: begin
				if ((rs == 5'd0 || rs == 5'd4) && sa == 5'd0 && fn[5:3] == 3'd0)
					w.st = mie_pkg::ST_EXT;
				else if (rs == 5'd16 && rt == 5'd0 && rd == 5'd0 && sa == 5'd0 &&
						(fn == 6'd8 || fn == 6'd2 || fn == 6'd6 || fn == 6'd24))
					w.st = mie_pkg::ST_EXT;
				else
					w.st = mie_pkg::ST_INV;
			end
			6'd28: begin
				if (fn == 6'd63) w.st = mie_pkg::ST_EXT;
				else if (sa != 5'd0) w.st = mie_pkg::ST_INV;
				else if (fn == 6'd2) begin w.wr = 1'b1; w.dst = rd; w.val = mulp; end
				else if (fn == 6'd32) begin w.wr = 1'b1; w.dst = rd; w.val = mie_pkg::clz32(a); end
				else if (fn == 6'd33) begin w.wr = 1'b1; w.dst = rd; w.val = mie_pkg::clz32(~a); end
				else w.st = mie_pkg::ST_INV;
			end
			6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38,
			6'd40, 6'd41, 6'd42, 6'd43, 6'd46: w.st = mie_pkg::ST_EXT;
			6'd60: w.st = (instruction == 32'hf000_0000) ? mie_pkg::ST_EXT : mie_pkg::ST_INV;
			default: w.st = mie_pkg::ST_INV;
		endcase
		if (w.st != mie_pkg::ST_OK) begin
			w.wr = 1'b0;
			w.hl = mie_pkg::OP_NONE;
			w.mtlo = 1'b0;
			w.npc = (w.st == mie_pkg::ST_EXT) ? seq : pc;
		end
		if (w.wr && w.dst == 5'd0) begin
			w.wr = 1'b0;
			if (w.hl == mie_pkg::OP_MFHI || w.hl == mie_pkg::OP_MFLO) w.hl = mie_pkg::OP_NONE;
		end
		if (!w.wr) begin
			w.dst = 5'd0;
			w.val = 32'd0;
		end
	end

	assign in_ready = !q_valid || q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_valid <= 1'b0;
		end else if (in_ready) begin
			q_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) q_data <= w;
	end

endmodule

[rtl/mie_queue.sv]
// Short FIFO between the front end and the back end.
// Depends on mie_pkg for the entry type and depth.
module mie_queue #(
	parameter int unsigned Depth = mie_pkg::QueueDepthC
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  mie_pkg::work_t  wr_data,
	output logic            rd_valid,
	input  logic            rd_ready,
	output mie_pkg::work_t  rd_data
);

	localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

	mie_pkg::work_t mem_q [Depth];
	logic [Aw-1:0] wp_q, rp_q;
	logic [Aw:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != (Aw+1)'(Depth);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

endmodule

[rtl/mie_back.sv]
// Back end: HI/LO state, iterative multiply and divide, and the output register.
// Depends on mie_pkg.
module mie_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  mie_pkg::work_t  q_data,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [31:0]     result,
	output logic [4:0]      dest_index,
	output logic            write_enable,
	output logic [31:0]     next_pc,
	output logic [2:0]      status
);

	typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIX} state_t;

	state_t state_q;
	logic [31:0] hi_q, lo_q;
	logic [31:0] mc_q, dv_q, quo_q;
	logic [31:0] rem_q;
	logic [63:0] acc_q;
	logic [5:0] cnt_q;
	logic neg_q, negq_q, negr_q;
	logic [63:0] mres;
	logic [32:0] trial;
	logic [32:0] rem_sh;
	logic out_free, take, simple, set_out;
	mie_pkg::work_t d;

	assign d = q_data;
	assign out_free = !out_valid || out_ready;
	assign simple = d.hl == mie_pkg::OP_NONE || d.hl == mie_pkg::OP_MFHI ||
		d.hl == mie_pkg::OP_MFLO || d.hl == mie_pkg::OP_MTHI;
	assign q_ready = state_q == S_IDLE && out_free;
	assign take = q_valid && q_ready;
	assign set_out = (take && simple) || (state_q == S_FIX && out_free);
	assign rem_sh = {rem_q, dv_q[31]};
	assign trial = rem_sh - {1'b0, mc_q};
	assign mres = neg_q ? (64'd0 - acc_q) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hi_q <= '0;
			lo_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (set_out) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (take) begin
					unique case (d.hl)
						mie_pkg::OP_NONE, mie_pkg::OP_MFHI, mie_pkg::OP_MFLO,
						mie_pkg::OP_MTHI: begin
							if (d.hl == mie_pkg::OP_MTHI) hi_q <= d.a;
							if (d.mtlo) lo_q <= d.a;
						end
						mie_pkg::OP_MULT, mie_pkg::OP_MULTU: state_q <= S_MUL;
						default: begin
							if (d.b == 32'd0) begin
								lo_q <= (d.hl == mie_pkg::OP_DIV && d.a[31]) ? 32'd1 : 32'hffff_ffff;
								hi_q <= d.a;
								state_q <= S_FIX;
							end else if (d.hl == mie_pkg::OP_DIV && d.a == 32'h8000_0000 &&
									d.b == 32'hffff_ffff) begin
								lo_q <= 32'h8000_0000;
								hi_q <= 32'd0;
								state_q <= S_FIX;
							end else begin
								state_q <= S_DIV;
							end
						end
					endcase
				end
				S_MUL: if (cnt_q == 6'd32) begin
					lo_q <= mres[31:0];
					hi_q <= mres[63:32];
					state_q <= S_FIX;
				end
				S_DIV: if (cnt_q == 6'd32) begin
					lo_q <= negq_q ? 32'd0 - quo_q : quo_q;
					hi_q <= negr_q ? 32'd0 - rem_q : rem_q;
					state_q <= S_FIX;
				end
				S_FIX: if (out_free) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && take) begin
			result <= (d.hl == mie_pkg::OP_MFHI) ? hi_q :
				(d.hl == mie_pkg::OP_MFLO) ? lo_q : d.val;
			dest_index <= d.dst;
			write_enable <= d.wr;
			next_pc <= d.npc;
			status <= d.st;
			cnt_q <= 6'd0;
			rem_q <= '0;
			quo_q <= '0;
			acc_q <= '0;
			if (d.hl == mie_pkg::OP_MULT) begin
				neg_q <= d.a[31] ^ d.b[31];
				mc_q <= d.a[31] ? 32'd0 - d.a : d.a;
				dv_q <= d.b[31] ? 32'd0 - d.b : d.b;
			end else if (d.hl == mie_pkg::OP_DIV) begin
				neg_q <= 1'b0;
				negq_q <= d.a[31] ^ d.b[31];
				negr_q <= d.a[31];
				dv_q <= d.a[31] ? 32'd0 - d.a : d.a;
				mc_q <= d.b[31] ? 32'd0 - d.b : d.b;
			end else begin
				neg_q <= 1'b0;
				negq_q <= 1'b0;
				negr_q <= 1'b0;
				if (d.hl == mie_pkg::OP_MULTU) begin
					mc_q <= d.a;
					dv_q <= d.b;
				end else begin
					dv_q <= d.a;
					mc_q <= d.b;
				end
			end
		end else if (state_q == S_MUL) begin
			cnt_q <= cnt_q + 6'd1;
			acc_q <= {1'b0, acc_q[63:1]} + (dv_q[0] ? {1'b0, mc_q, 31'd0} : 64'd0);
			dv_q <= {1'b0, dv_q[31:1]};
		end else if (state_q == S_DIV) begin
			cnt_q <= cnt_q + 6'd1;
			dv_q <= {dv_q[30:0], 1'b0};
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !q_ready)
		else $error("back end took an item while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV || state_q == S_MUL) |-> cnt_q <= 6'd32)
		else $error("iteration counter overran");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result) && $stable(next_pc))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!write_enable || dest_index != 5'd0))
		else $error("write to register zero");

endmodule

[rtl/mips32_integer_execute.sv]
// Top level of the MIPS32 integer execute block: front end, queue and back end.
// Depends on mie_pkg, mie_if, mie_front, mie_queue and mie_back.
//
// Usage: the in channel carries one instruction word with its pc and the rs
// and rt register values per beat. The out channel returns exactly one beat
// per instruction with the register write, the next pc and a status code.
// The front end decodes into its output register and places the item in a
// queue of QueueDepth entries, two by default. The back end holds HI and LO.
// An ordinary instruction passes the front register, a queue entry and the
// output register before it is offered on the out channel; such instructions
// follow at one per cycle while the receiver keeps ready high. Mult and
// multu run a shift-and-add loop and div and divu a restoring divider, 32
// iterations each, then a fix state; meanwhile the back end takes no item.
// Divide by zero and the most negative over minus one skip to the fix state.
// Reset clears HI, LO and all valid flags at once. When the receiver stalls,
// the output register holds its beat and the back end takes nothing more; the
// queue and the front register fill and then the in channel drops ready.
module mips32_integer_execute #(
	parameter int unsigned QueueDepth = mie_pkg::QueueDepthC
) (
	input logic clk,
	input logic arst_n,
	mie_if.sink   in_ch,
	mie_if.source out_ch
);

	logic f_valid, f_ready, b_valid, b_ready;
	mie_pkg::work_t f_data, b_data;

	mie_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.instruction (in_ch.data.instruction),
		.pc          (in_ch.data.pc),
		.rs_value    (in_ch.data.rs_value),
		.rt_value    (in_ch.data.rt_value),
		.q_valid     (f_valid),
		.q_ready     (f_ready),
		.q_data      (f_data)
	);

	mie_queue #(.Depth(QueueDepth)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_data),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_data)
	);

	mie_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (b_valid),
		.q_ready      (b_ready),
		.q_data       (b_data),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.result       (out_ch.data.result),
		.dest_index   (out_ch.data.dest_index),
		.write_enable (out_ch.data.write_enable),
		.next_pc      (out_ch.data.next_pc),
		.status       (out_ch.data.status)
	);

endmodule

[bench/tb_mips32_integer_execute.sv]
// Self-checking testbench for mips32_integer_execute: instruction beats go in,
// and every result beat is checked against a built-in predictor with its own HI/LO.
// Depends on mie_pkg, mie_if and the block's top level.
module tb_mips32_integer_execute;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] SignBit = 32'h8000_0000;
	localparam logic [31:0] AllOnes = 32'hffff_ffff;

	localparam logic [5:0] OpSpecial = 6'd0, OpRegimm = 6'd1, OpJ = 6'd2, OpJal = 6'd3;
	localparam logic [5:0] OpBeq = 6'd4, OpBne = 6'd5, OpBlez = 6'd6, OpBgtz = 6'd7;
	localparam logic [5:0] OpAddi = 6'd8, OpAddiu = 6'd9, OpSlti = 6'd10, OpSltiu = 6'd11;
	localparam logic [5:0] OpAndi = 6'd12, OpOri = 6'd13, OpXori = 6'd14, OpLui = 6'd15;
	localparam logic [5:0] OpCop0 = 6'd16, OpSpecial2 = 6'd28, OpLw = 6'd35, OpSw = 6'd43;
	localparam logic [5:0] OpSdbbpAlt = 6'd60;

	localparam logic [5:0] FnSll = 6'd0, FnSrl = 6'd2, FnSra = 6'd3, FnSllv = 6'd4;
	localparam logic [5:0] FnSrlv = 6'd6, FnSrav = 6'd7, FnJr = 6'd8, FnJalr = 6'd9;
	localparam logic [5:0] FnMovz = 6'd10, FnMovn = 6'd11, FnSyscall = 6'd12, FnSync = 6'd15;
	localparam logic [5:0] FnMfhi = 6'd16, FnMthi = 6'd17, FnMflo = 6'd18, FnMtlo = 6'd19;
	localparam logic [5:0] FnMult = 6'd24, FnMultu = 6'd25, FnDiv = 6'd26, FnDivu = 6'd27;
	localparam logic [5:0] FnAdd = 6'd32, FnAddu = 6'd33, FnSub = 6'd34, FnSubu = 6'd35;
	localparam logic [5:0] FnAnd = 6'd36, FnOr = 6'd37, FnXor = 6'd38, FnNor = 6'd39;
	localparam logic [5:0] FnSlt = 6'd42, FnSltu = 6'd43, FnTge = 6'd48, FnTgeu = 6'd49;
	localparam logic [5:0] FnTlt = 6'd50, FnTltu = 6'd51, FnTeq = 6'd52, FnTne = 6'd54;
	localparam logic [5:0] FnMul = 6'd2, FnClz = 6'd32, FnClo = 6'd33, FnSdbbp = 6'd63;
	localparam logic [5:0] FnEret = 6'd24;

	localparam logic [4:0] RtBltz = 5'd0, RtBgez = 5'd1, RtTgei = 5'd8, RtTgeiu = 5'd9;
	localparam logic [4:0] RtTlti = 5'd10, RtTltiu = 5'd11, RtTeqi = 5'd12, RtTnei = 5'd14;
	localparam logic [4:0] RtBltzal = 5'd16, RtBgezal = 5'd17;
	localparam logic [4:0] Cop0Co = 5'd16, LinkReg = 5'd31;

	typedef struct packed {
		logic [31:0] instruction;
		logic [31:0] pc;
		logic [31:0] rs_value;
		logic [31:0] rt_value;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] result;
		logic [4:0]  dest_index;
		logic        write_enable;
		logic [31:0] next_pc;
		logic [2:0]  status;
	} out_beat_t;

	typedef struct {
		in_beat_t beat;
		bit       drain;
	} pending_t;

	logic clk;
	logic arst_n;

	mie_if #(.payload_t(in_beat_t)) in_ch (.clk(clk));
	mie_if #(.payload_t(out_beat_t)) out_ch (.clk(clk));

	mips32_integer_execute u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	logic [31:0] hi_model;
	logic [31:0] lo_model;
	pending_t    instr_queue[$];
	out_beat_t   expected_q[$];
	int unsigned sent_count;
	int unsigned checked_count;
	int unsigned fail_count;
	int unsigned status_seen[8];
	int unsigned send_gap;
	int unsigned rx_stall;
	bit          long_hold_done;

	function automatic logic [31:0] lead_zeros(input logic [31:0] x);
		int unsigned n;
		n = 0;
		while (n < 32 && !x[31 - n]) n++;
		return n;
	endfunction

	function automatic out_beat_t execute_instr(input in_beat_t it);
		logic [31:0] ins, a, b, uimm, simm, seq, btarget, npc, val, r;
		logic [5:0]  op, fn;
		logic [4:0]  rs, rt, rd, sa, dst;
		logic [63:0] p;
		logic [31:0] ua, ub, q, rm;
		logic        wr, tk;
		mie_pkg::status_t st;
		out_beat_t   o;
		ins = it.instruction;
		a = it.rs_value;
		b = it.rt_value;
		op = ins[31:26];
		rs = ins[25:21];
		rt = ins[20:16];
		rd = ins[15:11];
		sa = ins[10:6];
		fn = ins[5:0];
		uimm = {16'd0, ins[15:0]};
		simm = {{16{ins[15]}}, ins[15:0]};
		seq = it.pc + 32'd4;
		btarget = seq + (simm << 2);
		npc = seq;
		st = mie_pkg::ST_OK;
		dst = '0;
		val = '0;
		wr = 1'b0;
		case (op)
			OpSpecial: begin
				case (fn)
					FnSll, FnSrl, FnSra: begin
						if (rs == 0) begin
							wr = 1'b1; dst = rd;
							val = (fn == FnSll) ? b << sa : (fn == FnSrl) ? b >> sa :
								32'($signed(b) >>> sa);
						end else st = mie_pkg::ST_INV;
					end
					FnSllv, FnSrlv, FnSrav: begin
						if (sa == 0) begin
							wr = 1'b1; dst = rd;
							val = (fn == FnSllv) ? b << a[4:0] : (fn == FnSrlv) ? b >> a[4:0] :
								32'($signed(b) >>> a[4:0]);
						end else st = mie_pkg::ST_INV;
					end
					FnJr: begin
						if (rt == 0 && rd == 0 && (sa == 0 || sa == 16)) npc = a;
						else st = mie_pkg::ST_INV;
					end
					FnJalr: begin
						if (rt == 0 && (sa == 0 || sa == 16)) begin
							wr = 1'b1; dst = rd; val = it.pc + 32'd8; npc = a;
						end else st = mie_pkg::ST_INV;
					end
					FnMovz, FnMovn: begin
						if (sa != 0) st = mie_pkg::ST_INV;
						else if ((fn == FnMovz) == (b == 0)) begin
							wr = 1'b1; dst = rd; val = a;
						end
					end
					FnSyscall: st = mie_pkg::ST_SYS;
					FnSync: if (rs != 0 || rt != 0 || rd != 0) st = mie_pkg::ST_INV;
					FnMfhi, FnMflo: begin
						if (rs == 0 && rt == 0 && sa == 0) begin
							wr = 1'b1; dst = rd; val = (fn == FnMfhi) ? hi_model : lo_model;
						end else st = mie_pkg::ST_INV;
					end
					FnMthi, FnMtlo: begin
						if (rt == 0 && rd == 0 && sa == 0) begin
							if (fn == FnMthi) hi_model = a;
							else lo_model = a;
						end else st = mie_pkg::ST_INV;
					end
					FnMult, FnMultu, FnDiv, FnDivu: begin
						if (rd != 0 || sa != 0) st = mie_pkg::ST_INV;
						else if (fn == FnMult) begin
							p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
							lo_model = p[31:0]; hi_model = p[63:32];
						end else if (fn == FnMultu) begin
							p = {32'd0, a} * {32'd0, b};
							lo_model = p[31:0]; hi_model = p[63:32];
						end else if (fn == FnDiv) begin
							if (b == 0) begin
								lo_model = a[31] ? 32'd1 : AllOnes; hi_model = a;
							end else if (a == SignBit && b == AllOnes) begin
								lo_model = SignBit; hi_model = '0;
							end else begin
								ua = a[31] ? -a : a;
								ub = b[31] ? -b : b;
								q = ua / ub; rm = ua % ub;
								if (a[31] ^ b[31]) q = -q;
								if (a[31]) rm = -rm;
								lo_model = q; hi_model = rm;
							end
						end else begin
							if (b == 0) begin
								lo_model = AllOnes; hi_model = a;
							end else begin
								lo_model = a / b; hi_model = a % b;
							end
						end
					end
					FnAdd, FnAddu, FnSub, FnSubu, FnAnd, FnOr, FnXor, FnNor, FnSlt, FnSltu: begin
						if (sa != 0) st = mie_pkg::ST_INV;
						else begin
							wr = 1'b1; dst = rd;
							case (fn)
								FnAdd: begin
									r = a + b; val = r;
									if ((a ^ r) & (b ^ r) & SignBit) st = mie_pkg::ST_OV;
								end
								FnAddu: val = a + b;
								FnSub: begin
									r = a - b; val = r;
									if ((a ^ b) & (a ^ r) & SignBit) st = mie_pkg::ST_OV;
								end
								FnSubu: val = a - b;
								FnAnd: val = a & b;
								FnOr: val = a | b;
								FnXor: val = a ^ b;
								FnNor: val = ~(a | b);
								FnSlt: val = {31'd0, $signed(a) < $signed(b)};
								default: val = {31'd0, a < b};
							endcase
						end
					end
					FnTge: if (!($signed(a) < $signed(b))) st = mie_pkg::ST_TRAP;
					FnTgeu: if (a >= b) st = mie_pkg::ST_TRAP;
					FnTlt: if ($signed(a) < $signed(b)) st = mie_pkg::ST_TRAP;
					FnTltu: if (a < b) st = mie_pkg::ST_TRAP;
					FnTeq: if (a == b) st = mie_pkg::ST_TRAP;
					FnTne: if (a != b) st = mie_pkg::ST_TRAP;
					default: st = mie_pkg::ST_INV;
				endcase
			end
			OpRegimm: begin
				case (rt)
					RtBltz, RtBltzal, RtBgez, RtBgezal: begin
						tk = (rt == RtBltz || rt == RtBltzal) ? a[31] : !a[31];
						if (tk && (rt == RtBltzal || rt == RtBgezal)) begin
							wr = 1'b1; dst = LinkReg; val = it.pc + 32'd8;
						end
						npc = tk ? btarget : it.pc + 32'd8;
					end
					RtTgei: if (!($signed(a) < $signed(simm))) st = mie_pkg::ST_TRAP;
					RtTgeiu: if (a >= simm) st = mie_pkg::ST_TRAP;
					RtTlti: if ($signed(a) < $signed(simm)) st = mie_pkg::ST_TRAP;
					RtTltiu: if (a < simm) st = mie_pkg::ST_TRAP;
					RtTeqi: if (a == simm) st = mie_pkg::ST_TRAP;
					RtTnei: if (a != simm) st = mie_pkg::ST_TRAP;
					default: st = mie_pkg::ST_INV;
				endcase
			end
			OpJ, OpJal: begin
				if (op == OpJal) begin
					wr = 1'b1; dst = LinkReg; val = it.pc + 32'd8;
				end
				npc = {seq[31:28], ins[25:0], 2'b00};
			end
			OpBeq: npc = (a == b) ? btarget : it.pc + 32'd8;
			OpBne: npc = (a != b) ? btarget : it.pc + 32'd8;
			OpBlez, OpBgtz: begin
				if (rt != 0) st = mie_pkg::ST_INV;
				else if ((op == OpBlez) == (a == 0 || a[31])) npc = btarget;
				else npc = it.pc + 32'd8;
			end
			OpAddi: begin
				r = a + simm;
				wr = 1'b1; dst = rt; val = r;
				if ((a ^ r) & (simm ^ r) & SignBit) st = mie_pkg::ST_OV;
			end
			OpAddiu: begin wr = 1'b1; dst = rt; val = a + simm; end
			OpSlti: begin wr = 1'b1; dst = rt; val = {31'd0, $signed(a) < $signed(simm)}; end
			OpSltiu: begin wr = 1'b1; dst = rt; val = {31'd0, a < simm}; end
			OpAndi: begin wr = 1'b1; dst = rt; val = a & uimm; end
			OpOri: begin wr = 1'b1; dst = rt; val = a | uimm; end
			OpXori: begin wr = 1'b1; dst = rt; val = a ^ uimm; end
			OpLui: begin
				if (rs == 0) begin wr = 1'b1; dst = rt; val = uimm << 16; end
				else st = mie_pkg::ST_INV;
			end
			OpCop0: begin
				if ((rs == 0 || rs == 4) && sa == 0 && fn[5:3] == 0) st = mie_pkg::ST_EXT;
				else if (rs == Cop0Co && rt == 0 && rd == 0 && sa == 0 &&
					(fn == 6'd8 || fn == 6'd2 || fn == 6'd6 || fn == FnEret))
					st = mie_pkg::ST_EXT;
				else st = mie_pkg::ST_INV;
			end
			OpSpecial2: begin
				if (fn == FnSdbbp) st = mie_pkg::ST_EXT;
				else if (sa != 0) st = mie_pkg::ST_INV;
				else if (fn == FnMul) begin wr = 1'b1; dst = rd; val = a * b; end
				else if (fn == FnClz) begin wr = 1'b1; dst = rd; val = lead_zeros(a); end
				else if (fn == FnClo) begin wr = 1'b1; dst = rd; val = lead_zeros(~a); end
				else st = mie_pkg::ST_INV;
			end
			6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38,
			6'd40, 6'd41, 6'd42, 6'd43, 6'd46: st = mie_pkg::ST_EXT;
			OpSdbbpAlt: st = (ins == 32'hf000_0000) ? mie_pkg::ST_EXT : mie_pkg::ST_INV;
			default: st = mie_pkg::ST_INV;
		endcase
		if (st != mie_pkg::ST_OK) begin
			wr = 1'b0;
			npc = (st == mie_pkg::ST_EXT) ? seq : it.pc;
		end
		if (wr && dst == 0) wr = 1'b0;
		if (!wr) begin
			dst = '0; val = '0;
		end
		o.result = val;
		o.dest_index = dst;
		o.write_enable = wr;
		o.next_pc = npc;
		o.status = st;
		return o;
	endfunction

	function automatic logic [31:0] enc_r(input logic [5:0] fn, input logic [4:0] rs,
		input logic [4:0] rt, input logic [4:0] rd, input logic [4:0] sa);
		return {OpSpecial, rs, rt, rd, sa, fn};
	endfunction

	function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
		input logic [4:0] rt, input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return AllOnes;
			2: return SignBit;
			3: return 32'h7fff_ffff;
			4: return 32'($urandom_range(0, 40));
			5: return -32'($urandom_range(1, 40));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] random_instr();
		logic [31:0] w;
		logic [5:0]  fn;
		logic [4:0]  rs, rt, rd, sa;
		logic [5:0]  fns[$];
		logic [4:0]  rts[$];
		logic [5:0]  ops[$];
		bit          tidy;
		w = $urandom;
		rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sa = w[10:6];
		tidy = $urandom_range(0, 4) != 0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				fns = '{FnSll, FnSrl, FnSra, FnSllv, FnSrlv, FnSrav, FnJr, FnJalr, FnMovz,
					FnMovn, FnSyscall, FnSync, FnMfhi, FnMthi, FnMflo, FnMtlo, FnMult,
					FnMultu, FnDiv, FnDivu, FnAdd, FnAddu, FnSub, FnSubu, FnAnd, FnOr,
					FnXor, FnNor, FnSlt, FnSltu, FnTge, FnTgeu, FnTlt, FnTltu, FnTeq, FnTne};
				fn = fns[$urandom_range(0, fns.size() - 1)];
				if (tidy) begin
					case (fn)
						FnSll, FnSrl, FnSra: rs = '0;
						FnJr: begin rt = '0; rd = '0; sa = '0; end
						FnJalr: begin rt = '0; sa = '0; end
						FnSync: begin rs = '0; rt = '0; rd = '0; end
						FnMfhi, FnMflo: begin rs = '0; rt = '0; sa = '0; end
						FnMthi, FnMtlo: begin rt = '0; rd = '0; sa = '0; end
						FnMult, FnMultu, FnDiv, FnDivu: begin rd = '0; sa = '0; end
						default: sa = '0;
					endcase
				end
				return enc_r(fn, rs, rt, rd, sa);
			end
			4: begin
				rts = '{RtBltz, RtBgez, RtBltzal, RtBgezal, RtTgei, RtTgeiu, RtTlti,
					RtTltiu, RtTeqi, RtTnei};
				if (tidy) rt = rts[$urandom_range(0, rts.size() - 1)];
				return enc_i(OpRegimm, rs, rt, w[15:0]);
			end
			5, 6: begin
				ops = '{OpJ, OpJal, OpBeq, OpBne, OpBlez, OpBgtz, OpAddi, OpAddiu, OpSlti,
					OpSltiu, OpAndi, OpOri, OpXori, OpLui};
				w[31:26] = ops[$urandom_range(0, ops.size() - 1)];
				if (tidy && (w[31:26] == OpBlez || w[31:26] == OpBgtz)) w[20:16] = '0;
				if (tidy && w[31:26] == OpLui) w[25:21] = '0;
				return w;
			end
			7: begin
				fns = '{FnMul, FnClz, FnClo, FnSdbbp};
				fn = fns[$urandom_range(0, fns.size() - 1)];
				return {OpSpecial2, rs, rt, rd, tidy ? 5'd0 : sa, fn};
			end
			8: begin
				case ($urandom_range(0, 3))
					0: return {OpCop0, tidy ? 5'd4 : rs, rt, rd, 5'd0, 3'd0, w[2:0]};
					1: return {OpCop0, Cop0Co, 10'd0, 5'd0, FnEret};
					2: return {6'($urandom_range(32, 46)), w[25:0]};
					default: return tidy ? 32'hf000_0000 : {OpSdbbpAlt, w[25:0]};
				endcase
			end
			default: return w;
		endcase
	endfunction

	task automatic add_item(input logic [31:0] ins, input logic [31:0] a, input logic [31:0] b);
		pending_t p;
		p.beat.instruction = ins;
		p.beat.pc = $urandom;
		p.beat.rs_value = a;
		p.beat.rt_value = b;
		p.drain = 1'b0;
		instr_queue.push_back(p);
	endtask

	task automatic add_drain();
		pending_t p;
		p.beat = '0;
		p.drain = 1'b1;
		instr_queue.push_back(p);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb_mips32_integer_execute: FAIL");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		logic valid_next;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			send_gap = 0;
			hi_model = '0;
			lo_model = '0;
		end else begin
			valid_next = in_ch.valid;
			if (in_ch.valid && in_ch.ready) begin
				expected_q.push_back(execute_instr(in_ch.data));
				sent_count++;
				valid_next = 1'b0;
				send_gap = ((sent_count / 40) % 3 == 0) ? 0 : $urandom_range(0, 14);
			end
			if (!valid_next) begin
				if (send_gap > 0) send_gap--;
				else if (instr_queue.size() > 0) begin
					if (instr_queue[0].drain) begin
						if (expected_q.size() == 0) void'(instr_queue.pop_front());
					end else begin
						in_ch.data <= instr_queue[0].beat;
						void'(instr_queue.pop_front());
						valid_next = 1'b1;
					end
				end
			end
			in_ch.valid <= valid_next;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		out_beat_t want, got;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				checked_count++;
				status_seen[got.status]++;
				if (expected_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result beat %p", $time, got);
				end else begin
					want = expected_q.pop_front();
					if (got.result !== want.result) begin
						fail_count++;
						$display("%0t: result expected %h actual %h", $time, want.result,
							got.result);
					end
					if (got.dest_index !== want.dest_index) begin
						fail_count++;
						$display("%0t: dest_index expected %0d actual %0d", $time,
							want.dest_index, got.dest_index);
					end
					if (got.write_enable !== want.write_enable) begin
						fail_count++;
						$display("%0t: write_enable expected %b actual %b", $time,
							want.write_enable, got.write_enable);
					end
					if (got.next_pc !== want.next_pc) begin
						fail_count++;
						$display("%0t: next_pc expected %h actual %h", $time, want.next_pc,
							got.next_pc);
					end
					if (got.status !== want.status) begin
						fail_count++;
						$display("%0t: status expected %0d actual %0d", $time, want.status,
							got.status);
					end
				end
				if (checked_count == 200 && !long_hold_done) begin
					rx_stall = 300;
					long_hold_done = 1'b1;
				end else if ((checked_count / 50) % 2 == 0) rx_stall = 0;
				else rx_stall = $urandom_range(0, 14);
			end else if (rx_stall > 0) rx_stall--;
			out_ch.ready <= (rx_stall == 0);
		end
	end

	initial begin
		logic [31:0] w;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		add_item(enc_r(FnSll, 5'd0, 5'd5, 5'd6, 5'd31), 32'd0, AllOnes);
		add_item(enc_r(FnAdd, 5'd1, 5'd2, 5'd3, 5'd0), 32'h7fff_ffff, 32'd1);
		add_item(enc_r(FnSub, 5'd1, 5'd2, 5'd3, 5'd0), SignBit, 32'd1);
		add_item(enc_i(OpAddi, 5'd1, 5'd2, 16'h8000), SignBit, 32'd0);
		add_item(enc_r(FnDiv, 5'd1, 5'd2, 5'd0, 5'd0), 32'd7, 32'd0);
		add_item(enc_r(FnMflo, 5'd0, 5'd0, 5'd4, 5'd0), 32'd0, 32'd0);
		add_item(enc_r(FnDiv, 5'd1, 5'd2, 5'd0, 5'd0), 32'hffff_fff9, 32'd0);
		add_item(enc_r(FnMfhi, 5'd0, 5'd0, 5'd4, 5'd0), 32'd0, 32'd0);
		add_item(enc_r(FnDivu, 5'd1, 5'd2, 5'd0, 5'd0), AllOnes, 32'd0);
		add_item(enc_r(FnDiv, 5'd1, 5'd2, 5'd0, 5'd0), SignBit, AllOnes);
		add_item(enc_r(FnMflo, 5'd0, 5'd0, 5'd9, 5'd0), 32'd0, 32'd0);
		add_item(enc_r(FnMult, 5'd1, 5'd2, 5'd0, 5'd0), SignBit, SignBit);
		add_item(enc_r(FnMfhi, 5'd0, 5'd0, 5'd9, 5'd0), 32'd0, 32'd0);
		add_item(enc_r(FnMthi, 5'd7, 5'd0, 5'd0, 5'd0), 32'h1234_5678, 32'd0);
		add_item(enc_r(FnMtlo, 5'd7, 5'd0, 5'd0, 5'd0), 32'h9abc_def0, 32'd0);
		add_item({OpSpecial2, 5'd1, 5'd0, 5'd8, 5'd0, FnClz}, 32'd0, 32'd0);
		add_item({OpSpecial2, 5'd1, 5'd0, 5'd8, 5'd0, FnClo}, AllOnes, 32'd0);
		add_item(enc_r(FnTeq, 5'd1, 5'd2, 5'd0, 5'd0), 32'd5, 32'd5);
		add_item(enc_r(FnSyscall, 5'd0, 5'd0, 5'd0, 5'd0), 32'd0, 32'd0);
		add_item(enc_i(OpRegimm, 5'd1, RtBgezal, 16'h8000), 32'd0, 32'd0);
		add_item(enc_i(OpRegimm, 5'd1, RtBltz, 16'h7fff), 32'd0, 32'd0);
		add_item({OpJal, 26'h3ff_ffff}, 32'd0, 32'd0);
		add_item(enc_r(FnAddu, 5'd1, 5'd2, 5'd0, 5'd0), 32'd3, 32'd4);
		add_item(enc_i(OpLw, 5'd1, 5'd2, 16'h0010), 32'd0, 32'd0);
		add_item(32'hf000_0000, 32'd0, 32'd0);
		add_drain();
		for (int i = 0; i < 450; i++) begin
			if (i == 220) add_drain();
			w = random_instr();
			add_item(w, pick_operand(), ($urandom_range(0, 5) == 0) ? 32'd0 : pick_operand());
		end
		wait (instr_queue.size() == 0 && expected_q.size() == 0 && !in_ch.valid);
		repeat (60) @(posedge clk);
		$display("Ran %0d instructions and checked %0d results: ok %0d, overflow %0d,",
			sent_count, checked_count, status_seen[mie_pkg::ST_OK],
			status_seen[mie_pkg::ST_OV]);
		$display("trap %0d, syscall %0d, handled elsewhere %0d, invalid %0d.",
			status_seen[mie_pkg::ST_TRAP], status_seen[mie_pkg::ST_SYS],
			status_seen[mie_pkg::ST_EXT], status_seen[mie_pkg::ST_INV]);
		if (fail_count == 0 && expected_q.size() == 0) begin
			$display("tb_mips32_integer_execute: PASS");
		end else begin
			$display("tb_mips32_integer_execute: FAIL");
		end
		$finish;
	end

endmodule
